### rtl/tpsi_pkg.sv
`timescale 1ns / 1ps

package tpsi_pkg;

  // pulse template, Q1.15 words, peak 1.0 exact in 17 bits
  localparam int unsigned TplLen = 100;
  localparam int unsigned TplW   = 17;
  localparam int TPL [TplLen] = '{
    -22, 64, 2, -77, -56, 14, 44,
    29, 6, -4, -6, -12, -24, -21,
    48, 240, 587, 1098, 1792, 2698, 3833,
    5191, 6764, 8550, 10546, 12733, 15076, 17527,
    20022, 22469, 24758, 26789, 28522, 29982, 31206,
    32125, 32623, 32768, 32594, 32072, 31218, 30101,
    28774, 27272, 25637, 23928, 22184, 20414, 18619,
    16815, 15026, 13289, 11648, 10148, 8821, 7670,
    6656, 5740, 4928, 4251, 3699, 3219, 2782,
    2405, 2103, 1864, 1664, 1485, 1322, 1172,
    1032, 899, 774, 652, 535, 423, 316,
    216, 123, 39, -36, -100, -152, -192,
    -218, -229, -227, -213, -190, -162, -130,
    -100, -70, -45, -22, -3, 14, 28,
    41, 52
  };

  // quotient: 7 integer bits of template index, 16 fraction bits
  localparam int unsigned IdxW  = 7;
  localparam int unsigned FracW = 16;
  localparam int unsigned QuoW  = IdxW + FracW;

  // divider operand widths
  localparam int unsigned NumW = 59;
  localparam int unsigned DenW = 51;

  // register stages from input beat to output register
  localparam int unsigned PipeDepth = 30;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_PED,
    KIND_INTERP
  } kind_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } ctl_t;

  typedef enum logic [2:0] {
    CFG_PEDESTAL = 3'd0,
    CFG_HEIGHT   = 3'd1,
    CFG_PHASE    = 3'd2,
    CFG_WIDTH    = 3'd3
  } cfg_idx_e;

  // template entry, zero past the last entry
  function automatic logic signed [TplW-1:0] tpl_at(logic [IdxW-1:0] i);
    logic signed [TplW-1:0] v;
    v = '0;
    if (int'(i) < int'(TplLen)) begin
      v = TplW'(TPL[i]);
    end
    return v;
  endfunction

endpackage

### rtl/tabulated_pulse_shape_interpolator_top.sv
`timescale 1ns / 1ps

// Evaluates pedestal + height * P(t) for one sample time per beat, where P is a
// 100-entry pulse template stretched by pulse_width, centered by phase and linearly
// interpolated; all values are signed Q16.16 and the level saturates. A beat can be
// taken every clock unless a held result stalls the output. Each beat passes the
// front stages, the 23-stage restoring divider that splits the template position
// into index and 16-bit fraction, and the back stages. An output stall holds the
// whole pipeline. Configuration writes are registered (the width-derived
// divisor and span once more) and belong to moments when no beat is in flight.
module tabulated_pulse_shape_interpolator_top
  import tpsi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] sample_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] level_o,
  output logic               in_window_o
);

  localparam int DW       = 46;
  localparam int Scale    = 1000;
  localparam int WinLead  = 3258;
  localparam int WinSpan  = 8806;
  localparam int PosScale = 11356;
  localparam int DenScale = 1000000;
  localparam int PW       = 65;
  localparam int IpW      = 33;

  logic signed [31:0] ped_q, hgt_q, phs_q, wid_q;
  logic [DenW-1:0]    den_q;
  logic signed [DW-1:0] lim_q;

  logic adv;

  ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q, ctld;
  ctl_t ctl1_d, ctl3_d;

  logic signed [32:0]   tp1_q;
  logic signed [DW-1:0] d2_q;
  logic [NumW-1:0]      num3_q;
  logic [QuoW-1:0]      quo;
  logic signed [TplW-1:0] lo4_q, hi4_q;
  logic [FracW-1:0]     frac4_q;
  logic signed [IpW-1:0] ip5_q;
  logic signed [PW-1:0] p6_q;

  logic signed [31:0] level_q;
  logic               inwin_q;
  logic               out_vld_q;

  // whole pipeline moves unless a finished result is held
  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ped_q <= 32'sd0;
      hgt_q <= 32'sd65536;
      phs_q <= 32'sd0;
      wid_q <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PEDESTAL: ped_q <= cfg_data_i;
        CFG_HEIGHT:   hgt_q <= cfg_data_i;
        CFG_PHASE:    phs_q <= cfg_data_i;
        CFG_WIDTH:    wid_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // width-derived divisor and window span
  always_ff @(posedge clk_i) begin
    den_q <= DenW'(wid_q[30:0]) * DenW'(DenScale);
    lim_q <= DW'(wid_q) * DW'(WinSpan);
  end

  // stage 1: special cases, time relative to phase
  always_comb begin
    ctl1_d.valid = in_valid_i;
    if (ped_q < 0 || phs_q < 0 || wid_q < 0) begin
      ctl1_d.kind = KIND_ZERO;
    end else if (wid_q == 32'sd0) begin
      ctl1_d.kind = KIND_PED;
    end else begin
      ctl1_d.kind = KIND_INTERP;
    end
  end

  // stage 3: window test, bounds inclusive
  always_comb begin
    ctl3_d = ctl2_q;
    if (ctl2_q.kind == KIND_INTERP && (d2_q < 0 || d2_q > lim_q)) begin
      ctl3_d.kind = KIND_PED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
    end else if (adv) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl3_d;
      ctl4_q <= ctld;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
    end
  end

  // front stages: offset, scaled distance from window start, dividend
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tp1_q  <= 33'(sample_time_i) - 33'(phs_q);
      d2_q   <= DW'(tp1_q) * DW'(Scale) + DW'(wid_q) * DW'(WinLead);
      num3_q <= NumW'(d2_q[DW-2:0]) * NumW'(PosScale);
    end
  end

  // template position = dividend / divisor, 16 fraction bits
  tpsi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl3_q),
    .num_i  (num3_q),
    .den_i  (den_q),
    .ctl_o  (ctld),
    .quo_o  (quo)
  );

  // back stages: template lookup, interpolation, scaling by height
  logic signed [TplW:0]  dlt;
  logic signed [34:0]    prod;
  logic signed [34:0]    ip_full;

  assign dlt     = (TplW+1)'(hi4_q) - (TplW+1)'(lo4_q);
  assign prod    = 35'(dlt) * 35'($signed({1'b0, frac4_q}));
  assign ip_full = 35'($signed({lo4_q, 16'b0})) + prod;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo4_q   <= tpl_at(quo[QuoW-1:FracW]);
      hi4_q   <= tpl_at(quo[QuoW-1:FracW] + IdxW'(1));
      frac4_q <= quo[FracW-1:0];
      ip5_q   <= ip_full[IpW-1:0];
      p6_q    <= PW'(hgt_q) * PW'(ip5_q);
    end
  end

  // rounding to Q16.16, pedestal add, saturation
  logic signed [PW-1:0] rnd;
  logic signed [33:0]   rsh;
  logic signed [34:0]   sum;
  logic signed [31:0]   sat;

  assign rnd = p6_q + (PW'(1) <<< 30);
  assign rsh = $signed(rnd[PW-1:31]);
  assign sum = 35'(ped_q) + 35'(rsh);

  always_comb begin
    if (sum > 35'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -35'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ctl6_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unique case (ctl6_q.kind)
        KIND_ZERO:   level_q <= 32'sd0;
        KIND_PED:    level_q <= ped_q;
        KIND_INTERP: level_q <= sat;
        default:     level_q <= 32'sd0;
      endcase
      inwin_q <= (ctl6_q.kind == KIND_INTERP);
    end
  end

  assign out_valid_o = out_vld_q;
  assign level_o     = level_q;
  assign in_window_o = inwin_q;

endmodule

### rtl/tpsi_div.sv
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
module tpsi_div
  import tpsi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  ctl_t            ctl_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output ctl_t            ctl_o,
  output logic [QuoW-1:0] quo_o
);

  localparam int unsigned NStg = QuoW;

  ctl_t            ctl_q [NStg];
  logic [NumW-1:0] rem_q [NStg];
  logic [QuoW-1:0] quo_q [NStg];

  for (genvar j = 0; j < NStg; j++) begin : g_stg
    localparam int Bit = int'(QuoW) - 1 - j;

    ctl_t            ctl_in;
    logic [NumW-1:0] rem_in;
    logic [QuoW-1:0] quo_in;
    logic [NumW-1:0] rem_sh;
    logic [NumW-1:0] trial;
    logic [NumW-1:0] diff;
    logic            take;

    // stage input
    if (j == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign rem_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // integer bits compare against shifted divisor, fraction bits shift the remainder
    if (Bit >= int'(FracW)) begin : g_int
      assign rem_sh = rem_in;
      assign trial  = NumW'(den_i) << (Bit - int'(FracW));
    end else begin : g_frac
      assign rem_sh = rem_in << 1;
      assign trial  = NumW'(den_i);
    end

    assign take = (rem_sh >= trial);
    assign diff = rem_sh - trial;

    // control
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j] <= '0;
      end else if (en_i) begin
        ctl_q[j] <= ctl_in;
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? diff : rem_sh;
        quo_q[j] <= {quo_in[QuoW-2:0], take};
      end
    end
  end

  assign ctl_o = ctl_q[NStg-1];
  assign quo_o = quo_q[NStg-1];

endmodule

### rtl/tpsi_chk.sv
`timescale 1ns / 1ps

// port-level checks for the pulse interpolator
module tpsi_chk
  import tpsi_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] level_o,
  input logic               in_window_o
);

  localparam int unsigned CntW = $clog2(PipeDepth + 1);

  logic            in_acc, out_acc;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // beats in flight
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // no result without a pending input beat
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0))
    else $error("result with no input beat in flight");

  // occupancy bounded by pipeline depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PipeDepth))
    else $error("more beats in flight than pipeline stages");

  // held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(level_o) && $stable(in_window_o)))
    else $error("stalled result changed");

endmodule

bind tabulated_pulse_shape_interpolator_top tpsi_chk u_tpsi_chk (.*);

### test/tabulated_pulse_shape_interpolator_top_tb.sv
`timescale 1ns / 1ps

module tabulated_pulse_shape_interpolator_top_tb;
  import tpsi_pkg::*;

  localparam int     ShapeLen   = 100;
  localparam int     RandPhases = 11;
  localparam int     RandItems  = 85;
  localparam int     HoldCycles = 600;
  localparam int     CycleLimit = 500000;
  localparam longint Q31Max     = (longint'(1) << 31) - 1;
  localparam longint Q31Min     = -(longint'(1) << 31);
  localparam logic [2:0] CfgSpare = 3'(CFG_WIDTH) + 3'd1;

  // pulse template in Q1.15
  localparam int ShapeTbl [ShapeLen] = '{
    -22, 64, 2, -77, -56, 14, 44,
    29, 6, -4, -6, -12, -24, -21,
    48, 240, 587, 1098, 1792, 2698, 3833,
    5191, 6764, 8550, 10546, 12733, 15076, 17527,
    20022, 22469, 24758, 26789, 28522, 29982, 31206,
    32125, 32623, 32768, 32594, 32072, 31218, 30101,
    28774, 27272, 25637, 23928, 22184, 20414, 18619,
    16815, 15026, 13289, 11648, 10148, 8821, 7670,
    6656, 5740, 4928, 4251, 3699, 3219, 2782,
    2405, 2103, 1864, 1664, 1485, 1322, 1172,
    1032, 899, 774, 652, 535, 423, 316,
    216, 123, 39, -36, -100, -152, -192,
    -218, -229, -227, -213, -190, -162, -130,
    -100, -70, -45, -22, -3, 14, 28,
    41, 52
  };

  typedef struct packed {
    logic signed [31:0] level;
    logic               in_window;
  } pulse_res_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [2:0]         cfg_idx_i     = '0;
  logic [31:0]        cfg_data_i    = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] sample_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic signed [31:0] level_o;
  logic               in_window_o;

  // shadow copy of the register file
  logic signed [31:0] ped_r   = 32'sd0;
  logic signed [31:0] amp_r   = 32'sd65536;
  logic signed [31:0] phase_r = 32'sd0;
  logic signed [31:0] width_r = 32'sd65536;

  logic signed [31:0] pending_times [$];
  pulse_res_t         predicted_levels [$];

  int   err_cnt      = 0;
  int   cycle_cnt    = 0;
  int   tx_gap       = 0;
  int   tx_burst     = 0;
  int   rx_wait      = 0;
  int   rx_burst     = 0;
  int   rx_hold_left = 0;
  bit   hold_done    = 1'b0;
  logic hold_req     = 1'b0;
  logic rx_holding   = 1'b0;

  tabulated_pulse_shape_interpolator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_time_i (sample_time_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .level_o       (level_o),
    .in_window_o   (in_window_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > Q31Max) return 32'sh7fff_ffff;
    if (v < Q31Min) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // expected level and window flag for one sample time
  function automatic pulse_res_t eval_pulse(logic signed [31:0] t);
    pulse_res_t   res;
    longint       w, d, lo, hi, interp, prod;
    logic [63:0]  num, den, idx, rem;
    logic [127:0] fr;
    res.level     = '0;
    res.in_window = 1'b0;
    if (ped_r < 0 || phase_r < 0 || width_r < 0) begin
      res.level = '0;
    end else if (width_r == 0) begin
      res.level = ped_r;
    end else begin
      w = longint'(width_r);
      d = 1000 * longint'(t) - 1000 * longint'(phase_r) + 3258 * w;
      if (d < 0 || d > 8806 * w) begin
        res.level = ped_r;
      end else begin
        // split position into template index and 16-bit fraction
        num    = 64'(d) * 64'd11356;
        den    = 64'd1000000 * 64'(w);
        idx    = num / den;
        rem    = num % den;
        fr     = (128'(rem) << 16) / 128'(den);
        lo     = (idx < ShapeLen) ? ShapeTbl[idx] : 0;
        hi     = (idx + 1 < ShapeLen) ? ShapeTbl[idx + 1] : 0;
        interp = lo * 65536 + (hi - lo) * longint'(fr[15:0]);
        // round to nearest, ties up, then add baseline with saturation
        prod          = longint'(amp_r) * interp + (longint'(1) <<< 30);
        res.level     = sat32(longint'(ped_r) + (prod >>> 31));
        res.in_window = 1'b1;
      end
    end
    return res;
  endfunction

  // idle cycles before the next beat, with bursts of back-to-back beats
  function automatic int draw_wait(inout int burst_left);
    int w;
    w = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(10, 50);
    end else begin
      w = $urandom_range(0, 17);
    end
    return w;
  endfunction

  // input side: present queued sample times, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      sample_time_i <= '0;
    end else begin : tx_side
      logic nxt_valid;
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predicted_levels.push_back(eval_pulse(sample_time_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_times.size() != 0) begin
          sample_time_i <= pending_times.pop_front();
          nxt_valid = 1'b1;
          tx_gap    = rx_holding ? 0 : draw_wait(tx_burst);
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // output side: compare each result beat, drive random stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_holding  <= 1'b0;
    end else begin : rx_side
      pulse_res_t want;
      if (out_valid_o && !out_stall_i) begin
        if (predicted_levels.size() == 0) begin
          if (err_cnt < 200) $error("unexpected result beat: level %0d", level_o);
          err_cnt++;
        end else begin
          want = predicted_levels.pop_front();
          if (level_o !== want.level) begin
            if (err_cnt < 200)
              $error("level: expected %0d, got %0d", $signed(want.level), level_o);
            err_cnt++;
          end
          if (in_window_o !== want.in_window) begin
            if (err_cnt < 200)
              $error("in_window: expected %0b, got %0b", want.in_window, in_window_o);
            err_cnt++;
          end
        end
        rx_wait = draw_wait(rx_burst);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      // one long hold so the pipeline backs up into the input
      if (rx_hold_left > 0) begin
        rx_hold_left--;
      end else if (hold_req && !hold_done) begin
        rx_hold_left = HoldCycles;
        hold_done    = 1'b1;
      end
      out_stall_i <= (rx_wait > 0) || (rx_hold_left > 0);
      rx_holding  <= (rx_hold_left > 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_PEDESTAL: ped_r   = data;
      CFG_HEIGHT:   amp_r   = data;
      CFG_PHASE:    phase_r = data;
      CFG_WIDTH:    width_r = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [31:0] ped, logic [31:0] amp, logic [31:0] ph,
                              logic [31:0] wd, bit with_spare = 1'b0);
    write_reg(CFG_PEDESTAL, ped);
    write_reg(CFG_HEIGHT, amp);
    write_reg(CFG_PHASE, ph);
    write_reg(CFG_WIDTH, wd);
    // unmapped indexes must leave the registers alone
    if (with_spare) begin
      for (int s = 0; s < 4; s++) write_reg(CfgSpare + 3'(s), $urandom);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_times.size() != 0 || in_valid_i || predicted_levels.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // window bounds first if asked, then mostly in-window times
  task automatic queue_samples(int n, bit edges);
    longint      w, t_lo, t_hi, v;
    logic [63:0] r64;
    int          sel;
    w    = (width_r > 0) ? longint'(width_r) : 65536;
    t_lo = longint'(phase_r) - (3258 * w) / 1000;
    t_hi = longint'(phase_r) + (5548 * w) / 1000;
    if (edges) begin
      pending_times.push_back(sat32(t_lo - 1));
      pending_times.push_back(sat32(t_lo));
      pending_times.push_back(sat32(t_hi));
      pending_times.push_back(sat32(t_hi + 1));
      pending_times.push_back(phase_r);
    end
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 19);
      r64 = {$urandom, $urandom};
      if (sel < 15) begin
        v = t_lo + longint'(r64 % 64'(t_hi - t_lo + 1));
      end else if (sel < 17) begin
        v = ((sel == 15) ? t_lo : t_hi) + $signed($urandom_range(0, 6)) - 3;
      end else begin
        v = longint'($signed(r64[31:0]));
      end
      pending_times.push_back(sat32(v));
    end
  endtask

  function automatic logic [31:0] pick_reg(cfg_idx_e which);
    int          sel;
    logic [31:0] v;
    sel = $urandom_range(0, 19);
    v   = '0;
    case (which)
      CFG_PEDESTAL:
        v = (sel < 16) ? $urandom_range(0, 1 << 20) :
            (sel == 16) ? ($urandom | 32'h8000_0000) :
            (sel == 17) ? 32'h7fff_ffff : ($urandom >> 1);
      CFG_HEIGHT:
        v = (sel < 12) ? ($urandom_range(0, 1 << 21) - (1 << 20)) :
            (sel < 17) ? $urandom :
            (sel == 17) ? 32'h8000_0000 : 32'h7fff_ffff;
      CFG_PHASE:
        v = (sel < 16) ? $urandom_range(0, 1 << 22) :
            (sel < 19) ? ($urandom >> 1) : ($urandom | 32'h8000_0000);
      default:
        v = (sel < 11) ? $urandom_range(1 << 12, 1 << 18) :
            (sel < 14) ? $urandom_range(1, 4096) :
            (sel < 18) ? ($urandom >> 1) :
            (sel == 18) ? 32'h0 : ($urandom | 32'h8000_0000);
    endcase
    return v;
  endfunction

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // settings out of reset, time extremes and window bounds
    pending_times.push_back(32'sh8000_0000);
    pending_times.push_back(32'sh7fff_ffff);
    queue_samples(0, 1'b1);
    wait_idle();

    // width chosen so the window end lands exactly past the last entry
    apply_config(32'd1000, 32'h7fff_ffff, 32'h0001_0000, 32'd65500);
    queue_samples(0, 1'b1);
    wait_idle();

    // positive saturation at the peak
    apply_config(32'h7fff_ffff, 32'h0010_0000, 32'h0, 32'h0001_0000);
    pending_times.push_back('0);
    wait_idle();

    // most negative height at the peak
    apply_config(32'h0, 32'h8000_0000, 32'h0, 32'h0001_0000);
    pending_times.push_back('0);
    wait_idle();

    // negative pedestal, negative phase, negative width give zero
    apply_config(32'hffff_0000, 32'h0001_0000, 32'h0, 32'h0001_0000);
    pending_times.push_back('0);
    wait_idle();
    apply_config(32'h0, 32'h0001_0000, 32'hffff_ffff, 32'h0001_0000);
    pending_times.push_back('0);
    wait_idle();
    apply_config(32'h0, 32'h0001_0000, 32'h0, 32'h8000_0000);
    pending_times.push_back('0);
    wait_idle();

    // zero width returns the pedestal
    apply_config(32'd5000, 32'h0001_0000, 32'h0, 32'h0);
    pending_times.push_back('0);
    pending_times.push_back(32'sh7fff_ffff);
    wait_idle();

    // writes to unmapped indexes
    apply_config(32'd5000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1);
    pending_times.push_back('0);
    wait_idle();

    // random settings, each with a batch of random times
    for (int k = 0; k < RandPhases; k++) begin
      case (k)
        0: apply_config(32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        1: apply_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        default: apply_config(pick_reg(CFG_PEDESTAL), pick_reg(CFG_HEIGHT),
                              pick_reg(CFG_PHASE), pick_reg(CFG_WIDTH));
      endcase
      if (k == 2) hold_req <= 1'b1;
      queue_samples((k == 1) ? 20 : RandItems, 1'b1);
      wait_idle();
    end

    repeat (PipeDepth + 8) @(posedge clk_i);
    if (err_cnt == 0 && predicted_levels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
